### rtl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// Three-class priority queue package
// Shared types, codes and default sizes for the queue and its storage cells.
// ----------------------------------------------------------------------------
package tcpq_pkg;

   localparam int DEPTH_DEFAULT         = 32;
   localparam int PAYLOAD_WIDTH_DEFAULT = 32;

   localparam logic [1:0] CLASS_LOWEST = 2'd2;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      command_type command;
      logic [31:0] payload;
      logic [1:0]  item_class;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] head_payload;
      logic [1:0]  head_class;
      logic [5:0]  occupancy;
   } rsp_type;

   // Operation broadcast to every cell of the chain.
   typedef struct packed {
      logic       enq;
      logic       deq;
      logic [1:0] item_class;
   } cell_ctrl_type;

endpackage

### rtl/tcpq_cell.sv
// ----------------------------------------------------------------------------
// Priority queue storage cell
// Holds one entry and, each cycle, keeps it, takes the new entry, takes the
// entry of its upstream neighbour (insert) or of its downstream neighbour
// (remove).
// ----------------------------------------------------------------------------
module tcpq_cell #(
   parameter int PAYLOAD_WIDTH = tcpq_pkg::PAYLOAD_WIDTH_DEFAULT,
   parameter int CNT_W         = 6,
   parameter int INDEX         = 0
) (
   input  logic                      clock,
   input  tcpq_pkg::cell_ctrl_type   ctrl,
   input  logic [PAYLOAD_WIDTH-1:0]  new_payload,
   input  logic [CNT_W-1:0]          count,
   input  logic                      prev_keep,
   input  logic [PAYLOAD_WIDTH-1:0]  prev_payload,
   input  logic [1:0]                prev_class,
   input  logic [PAYLOAD_WIDTH-1:0]  next_payload,
   input  logic [1:0]                next_class,
   output logic                      keep,
   output logic [PAYLOAD_WIDTH-1:0]  payload,
   output logic [1:0]                entry_class
);

   localparam logic [CNT_W-1:0] POS = CNT_W'(INDEX);

   logic [PAYLOAD_WIDTH-1:0] payload_ff, payload_in;
   logic [1:0]               class_ff, class_in;

   // An occupied entry of equal or higher class stays where it is.
   assign keep = (POS < count) && (class_ff <= ctrl.item_class);

   always_comb begin
      payload_in = payload_ff;
      class_in   = class_ff;
      if (ctrl.deq) begin
         payload_in = next_payload;
         class_in   = next_class;
      end else if (ctrl.enq && !keep) begin
         if (prev_keep) begin
            payload_in = new_payload;
            class_in   = ctrl.item_class;
         end else begin
            payload_in = prev_payload;
            class_in   = prev_class;
         end
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      class_ff   <= class_in;
   end

   assign payload     = payload_ff;
   assign entry_class = class_ff;

endmodule

### rtl/three_class_priority_queue_top.sv
// ----------------------------------------------------------------------------
// Three-class priority queue
// Bounded, stable priority queue built as a chain of storage cells.
// ----------------------------------------------------------------------------
// A transaction accepted at one edge has its result on rsp_data, with
// rsp_strobe high, for the following cycle only, and busy is never raised,
// so a new transaction may be issued every cycle. Each cell compares its own
// class with the incoming one, and the entries move one step along the chain
// when the command is accepted.
// ----------------------------------------------------------------------------
module three_class_priority_queue_top #(
   parameter int DEPTH         = tcpq_pkg::DEPTH_DEFAULT,
   parameter int PAYLOAD_WIDTH = tcpq_pkg::PAYLOAD_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tcpq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output tcpq_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   logic                    accept;
   logic                    is_full, is_empty;
   logic [1:0]              cls;
   tcpq_pkg::cell_ctrl_type ctrl;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    strobe_ff, strobe_in;
   tcpq_pkg::rsp_type       rsp_ff, rsp_in;
   logic [PAYLOAD_WIDTH-1:0] new_payload;
   logic [31:0]              head_payload;

   logic                     keep_w    [DEPTH];
   logic [PAYLOAD_WIDTH-1:0] payload_w [DEPTH];
   logic [1:0]               class_w   [DEPTH];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff == FULL_COUNT);
   assign is_empty = (count_ff == '0);
   assign cls      = (req_data.item_class > tcpq_pkg::CLASS_LOWEST) ?
                     tcpq_pkg::CLASS_LOWEST : req_data.item_class;

   generate
      if (PAYLOAD_WIDTH >= 32) begin : g_wide
         assign new_payload  = PAYLOAD_WIDTH'(req_data.payload);
         assign head_payload = payload_w[0][31:0];
      end else begin : g_narrow
         assign new_payload  = req_data.payload[PAYLOAD_WIDTH-1:0];
         assign head_payload = 32'(payload_w[0]);
      end
   endgenerate

   assign ctrl.enq = accept && (req_data.command == tcpq_pkg::CMD_ENQUEUE) && !is_full;
   assign ctrl.deq = accept && (req_data.command == tcpq_pkg::CMD_DEQUEUE) && !is_empty;
   assign ctrl.item_class = cls;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic                     prev_keep;
         logic [PAYLOAD_WIDTH-1:0] prev_payload, next_payload;
         logic [1:0]               prev_class, next_class;

         if (i == 0) begin : g_first
            assign prev_keep    = 1'b1;
            assign prev_payload = '0;
            assign prev_class   = '0;
         end else begin : g_mid
            assign prev_keep    = keep_w[i-1];
            assign prev_payload = payload_w[i-1];
            assign prev_class   = class_w[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            assign next_payload = '0;
            assign next_class   = '0;
         end else begin : g_inner
            assign next_payload = payload_w[i+1];
            assign next_class   = class_w[i+1];
         end

         tcpq_cell #(
            .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
            .CNT_W         (CNT_W),
            .INDEX         (i)
         ) u_cell (
            .clock        (clock),
            .ctrl         (ctrl),
            .new_payload  (new_payload),
            .count        (count_ff),
            .prev_keep    (prev_keep),
            .prev_payload (prev_payload),
            .prev_class   (prev_class),
            .next_payload (next_payload),
            .next_class   (next_class),
            .keep         (keep_w[i]),
            .payload      (payload_w[i]),
            .entry_class  (class_w[i])
         );
      end
   endgenerate

   always_comb begin
      count_in  = count_ff;
      strobe_in = accept;
      rsp_in    = rsp_ff;
      if (ctrl.enq) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.deq) begin
         count_in = count_ff - 1'b1;
      end
      if (accept) begin
         rsp_in.status       = tcpq_pkg::ST_DONE;
         rsp_in.head_payload = '0;
         rsp_in.head_class   = '0;
         if (req_data.command == tcpq_pkg::CMD_ENQUEUE) begin
            if (is_full) begin
               rsp_in.status = tcpq_pkg::ST_FULL;
            end
         end else if (is_empty) begin
            rsp_in.status = tcpq_pkg::ST_EMPTY;
         end else begin
            rsp_in.head_class   = class_w[0];
            rsp_in.head_payload = head_payload;
         end
         rsp_in.occupancy = 6'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // The entry count can never pass the queue depth.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count exceeds queue depth");

   // Every accepted transaction yields a result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted transaction produced no result");

   // A successful enqueue grows the count by exactly one.
   a_enqueue_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.enq |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("enqueue did not advance the count");

   // A dequeue on an empty queue reports empty and returns nothing.
   a_empty_dequeue: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.command == tcpq_pkg::CMD_DEQUEUE && is_empty) |=>
      (rsp_data.status == tcpq_pkg::ST_EMPTY && rsp_data.head_payload == '0
       && rsp_data.head_class == '0))
      else $error("empty dequeue reported wrongly");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the three-class priority queue
// Drives enqueue and dequeue commands through the start/busy handshake and
// checks every strobed response against a cycle-free model of the queue kept
// in a small scoreboard class. Directed commands cover the extremes and the
// special cases. Random runs then fill the queue past full, drain it past
// empty and mix the two, under several sender idling patterns.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int QUEUE_DEPTH = tcpq_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 100000;

   // -------------------------------------------------------------------------
   // Scoreboard: models the stored entries and holds the predicted responses.
   // -------------------------------------------------------------------------
   class priority_queue_tracker;
      logic [31:0]       slot_tag[QUEUE_DEPTH];
      logic [1:0]        slot_class[QUEUE_DEPTH];
      int                held;
      tcpq_pkg::rsp_type expected_rsps[$];
      int                errors;
      int                n_enq;
      int                n_full;
      int                n_deq;
      int                n_empty;
      int                peak;

      function new();
         held    = 0;
         errors  = 0;
         n_enq   = 0;
         n_full  = 0;
         n_deq   = 0;
         n_empty = 0;
         peak    = 0;
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("mismatch: %s: got %0h, expected %0h", what, got, want);
         errors++;
      endtask

      // Works out the response to one accepted transaction and updates the model.
      function void note_command(tcpq_pkg::req_type r);
         tcpq_pkg::rsp_type want;
         int                pos;
         logic [1:0]        cls;
         want        = '0;
         want.status = tcpq_pkg::ST_DONE;
         if (r.command == tcpq_pkg::CMD_ENQUEUE) begin
            // Class three is folded into the lowest class before it is stored.
            cls = (r.item_class > tcpq_pkg::CLASS_LOWEST) ?
                  tcpq_pkg::CLASS_LOWEST : r.item_class;
            if (held >= QUEUE_DEPTH) begin
               want.status = tcpq_pkg::ST_FULL;
               n_full++;
            end else begin
               pos = 0;
               while (pos < held && slot_class[pos] <= cls) pos++;
               for (int i = held; i > pos; i--) begin
                  slot_tag[i]   = slot_tag[i - 1];
                  slot_class[i] = slot_class[i - 1];
               end
               slot_tag[pos]   = r.payload;
               slot_class[pos] = cls;
               held++;
               n_enq++;
               if (held > peak) peak = held;
            end
         end else begin
            if (held == 0) begin
               want.status = tcpq_pkg::ST_EMPTY;
               n_empty++;
            end else begin
               want.head_payload = slot_tag[0];
               want.head_class   = slot_class[0];
               for (int i = 0; i + 1 < held; i++) begin
                  slot_tag[i]   = slot_tag[i + 1];
                  slot_class[i] = slot_class[i + 1];
               end
               held--;
               n_deq++;
            end
         end
         want.occupancy = held[5:0];
         expected_rsps.push_back(want);
      endfunction

      task check_response(tcpq_pkg::rsp_type got);
         tcpq_pkg::rsp_type want;
         if (expected_rsps.size() == 0) begin
            report_mismatch("response with no transaction waiting", longint'(got), 0);
         end else begin
            want = expected_rsps.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", longint'(got.status),
                               longint'(want.status));
            if (got.head_payload !== want.head_payload)
               report_mismatch("head_payload", longint'(got.head_payload),
                               longint'(want.head_payload));
            if (got.head_class !== want.head_class)
               report_mismatch("head_class", longint'(got.head_class),
                               longint'(want.head_class));
            if (got.occupancy !== want.occupancy)
               report_mismatch("occupancy", longint'(got.occupancy),
                               longint'(want.occupancy));
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   tcpq_pkg::req_type req_data;
   logic              rsp_strobe;
   tcpq_pkg::rsp_type rsp_data;
   int                cycle_count = 0;

   priority_queue_tracker tracker = new();

   three_class_priority_queue_top u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped: cycle limit reached with %0d responses outstanding",
                  tracker.pending());
         $display("[three_class_priority_queue_top] ERROR");
         $finish;
      end
   end

   // The response of the previous transaction is checked before the one
   // accepted at this edge is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) tracker.check_response(rsp_data);
         if (start && !busy) tracker.note_command(req_data);
      end
   end

   // Offers one transaction, idling first with the given chance per cycle.
   // Start is left high on return so that back-to-back transactions follow.
   task send_command(input tcpq_pkg::command_type cmd, input logic [31:0] tag,
                     input logic [1:0] cls, input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start               <= 1'b1;
      req_data.command    <= cmd;
      req_data.payload    <= tag;
      req_data.item_class <= cls;
      do @(posedge clock); while (busy);
   endtask

   task wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Segments of forty transactions each lean towards filling, draining,
   // overflowing or a balanced mix; the first ten of a segment never idle.
   task run_random(input int n_items, input int idle_pct);
      int                    mode;
      int                    p_deq;
      int                    gap;
      logic [31:0]           tag;
      tcpq_pkg::command_type cmd;
      mode = 0;
      for (int k = 0; k < n_items; k++) begin
         if (k % 40 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0:       p_deq = 15;
            1:       p_deq = 85;
            2:       p_deq = 50;
            default: p_deq = 0;
         endcase
         cmd = ($urandom_range(0, 99) < p_deq) ? tcpq_pkg::CMD_DEQUEUE :
                                                 tcpq_pkg::CMD_ENQUEUE;
         case ($urandom_range(0, 7))
            0:       tag = '0;
            1:       tag = '1;
            default: tag = $urandom;
         endcase
         gap = ((k % 40) < 10) ? 0 : idle_pct;
         send_command(cmd, tag, 2'($urandom_range(0, 3)), gap);
      end
   endtask

   initial begin
      int idle_pct[4];
      idle_pct = '{0, 49, 0, 20};

      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: dequeue on empty, every class including three, payload
      // extremes, ordering within and across classes, then empty again.
      send_command(tcpq_pkg::CMD_DEQUEUE, 32'hFFFF_FFFF, 2'd3, 0);
      send_command(tcpq_pkg::CMD_ENQUEUE, 32'h0000_0000, 2'd2, 0);
      send_command(tcpq_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF, 2'd1, 0);
      send_command(tcpq_pkg::CMD_ENQUEUE, 32'hA5A5_A5A5, 2'd0, 0);
      send_command(tcpq_pkg::CMD_ENQUEUE, 32'h5A5A_5A5A, 2'd3, 0);
      send_command(tcpq_pkg::CMD_ENQUEUE, 32'h0000_0001, 2'd1, 0);
      send_command(tcpq_pkg::CMD_ENQUEUE, 32'h8000_0000, 2'd0, 0);
      send_command(tcpq_pkg::CMD_ENQUEUE, 32'h1234_5678, 2'd2, 0);
      for (int i = 0; i < 8; i++)
         send_command(tcpq_pkg::CMD_DEQUEUE, $urandom, 2'($urandom_range(0, 3)), 0);
      send_command(tcpq_pkg::CMD_ENQUEUE, 32'hDEAD_BEEF, 2'd3, 0);
      send_command(tcpq_pkg::CMD_DEQUEUE, 32'h0, 2'd0, 0);
      wait_for_drain();

      for (int p = 0; p < 4; p++) begin
         run_random(200, idle_pct[p]);
         wait_for_drain();
      end

      if (tracker.pending() != 0)
         tracker.report_mismatch("responses never arrived",
                                 longint'(tracker.pending()), 0);

      $display("covered %0d enqueues, %0d full rejections, %0d dequeues, %0d empty dequeues",
               tracker.n_enq, tracker.n_full, tracker.n_deq, tracker.n_empty);
      $display("peak occupancy %0d of %0d over %0d cycles, four idling phases",
               tracker.peak, QUEUE_DEPTH, cycle_count);
      if (tracker.errors == 0) begin
         $display("[three_class_priority_queue_top] OK");
      end else begin
         $display("[three_class_priority_queue_top] ERROR");
      end
      $finish;
   end

endmodule
